/* rtl/harris_response_nms_threshold_core_defines.svh */
// Assertion macros shared by the checker of the Harris NMS core
`ifndef HARRIS_RESPONSE_NMS_THRESHOLD_CORE_DEFINES_SVH
`define HARRIS_RESPONSE_NMS_THRESHOLD_CORE_DEFINES_SVH

// same-cycle implication
`define HRNT_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hrnt assertion failed");

// next-cycle implication
`define HRNT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hrnt assertion failed");

`endif

/* rtl/hrnt_pkg.sv */
// Types and constants of the Harris response NMS threshold core
package hrnt_pkg;

  localparam int MAX_WIDTH = 1024;  // widest row

  localparam int CW    = 11;  // column counters
  localparam int RW    = 12;  // row counters
  localparam int RADW  = 3;   // radius
  localparam int RESPW = 52;  // response
  localparam int PW    = 23;  // row*width+column
  localparam int DW    = 80;  // tdata width, both sides

  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_RADIUS = 3'd2;
  localparam logic [2:0] REG_THRESH = 3'd3;
  localparam logic [2:0] REG_ALPHA  = 3'd4;

  localparam logic REQ_FLUSH = 1'b1;

  localparam logic signed [RESPW-1:0] RESP_MIN = {1'b1, {(RESPW-1){1'b0}}};
  localparam logic signed [RESPW-1:0] RESP_MAX = {1'b0, {(RESPW-1){1'b1}}};

  typedef struct packed {
    logic [CW-1:0]             w;
    logic [RW-1:0]             h;
    logic [RADW-1:0]           r;
    logic signed [RESPW-1:0]   thr;
    logic [15:0]               alpha;
  } cfg_t;

  typedef struct packed {
    logic                    wr;
    logic [CW-1:0]           wx;
    logic [RW-1:0]           wy;
    logic signed [RESPW-1:0] value;
    logic                    emit;
    logic [CW-1:0]           cx;
    logic [RW-1:0]           cy;
    logic [CW-1:0]           ox;
    logic [RW-1:0]           oy;
    logic                    fe;
  } cmd_t;

endpackage

/* rtl/hrnt_ram.sv */
// Generic single-port RAM with registered read
module hrnt_ram #(
  parameter int WIDTH = 52,
  parameter int DEPTH = 9216
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end
endmodule

/* rtl/hrnt_cmd_fifo.sv */
// Two-entry command queue between front and back
module hrnt_cmd_fifo import hrnt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output cmd_t dout,
  output logic empty
);
  cmd_t       slots [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       push_ok, pop_ok;

  assign full    = (cnt == 2'd2);
  assign empty   = (cnt == 2'd0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign dout    = slots[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push_ok) wp <= ~wp;
      if (pop_ok) rp <= ~rp;
      cnt <= cnt + {1'b0, push_ok} - {1'b0, pop_ok};
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slots[wp] <= din;
    end
  end
endmodule

/* rtl/hrnt_front.sv */
// Front: accepts items, computes the response, tracks positions, queues commands
module hrnt_front import hrnt_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [DW-1:0] s_tdata,
  input  logic          s_tuser,
  output logic          cmd_push,
  output cmd_t          cmd,
  input  logic          cmd_full
);
  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_S1   = 2'd1;
  localparam logic [1:0] F_S2   = 2'd2;
  localparam logic [1:0] F_S3   = 2'd3;

  logic [1:0] state;

  logic [23:0]        sxx_r, syy_r;
  logic signed [24:0] sxy_r;
  logic               flush_r;

  logic [47:0]        p_xy;
  logic [48:0]        p_s;
  logic [49:0]        t2;
  logic [PW-1:0]      q_mul;
  logic [13:0]        d_mul;
  logic signed [50:0] det;
  logic [49:0]        term;
  logic               ge;

  logic [CW-1:0] in_col, out_col;
  logic [RW-1:0] in_row, out_row;

  logic [24:0]        tr;
  logic signed [49:0] sq;
  logic [65:0]        tprod;
  logic [PW-1:0]      q_sum, d_sum;
  logic signed [52:0] resp53;
  logic signed [RESPW-1:0] resp;
  logic          open, wr, emit, fe, col_end, out_col_end;
  logic [CW-1:0] cx;
  logic [RW-1:0] cy;

  assign s_tready = (state == F_IDLE);

  always_comb begin
    tr    = {1'b0, sxx_r} + {1'b0, syy_r};
    sq    = sxy_r * sxy_r;
    tprod = t2 * cfg.alpha;
    q_sum = q_mul + PW'(in_col);
    d_sum = PW'(d_mul) + PW'(cfg.r);
    resp53 = {{2{det[50]}}, det} - $signed({3'b000, term});
    if (resp53[52:51] == {2{resp53[51]}}) begin
      resp = resp53[RESPW-1:0];
    end else begin
      resp = resp53[52] ? RESP_MIN : RESP_MAX;
    end
  end

  // classification of the item
  always_comb begin
    open        = (in_row < cfg.h);
    wr          = open && (flush_r != REQ_FLUSH);
    emit        = open ? (wr && ge) : 1'b1;
    cx          = (out_col < cfg.w) ? out_col : cfg.w - CW'(1);
    cy          = (out_row < cfg.h) ? out_row : cfg.h - RW'(1);
    out_col_end = ({1'b0, out_col} + 12'd1) >= {1'b0, cfg.w};
    fe          = (({1'b0, out_row} + 13'd1) >= {1'b0, cfg.h}) && out_col_end;
    col_end     = ({1'b0, in_col} + 12'd1) >= {1'b0, cfg.w};
    cmd.wr    = wr;
    cmd.wx    = in_col;
    cmd.wy    = in_row;
    cmd.value = resp;
    cmd.emit  = emit;
    cmd.cx    = cx;
    cmd.cy    = cy;
    cmd.ox    = out_col;
    cmd.oy    = out_row;
    cmd.fe    = fe;
  end

  assign cmd_push = (state == F_S3) && (wr || emit) && !cmd_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= F_IDLE;
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (s_tvalid) state <= F_S1;
        end
        F_S1: state <= F_S2;
        F_S2: state <= F_S3;
        F_S3: begin
          if (!(wr || emit) || !cmd_full) begin
            state <= F_IDLE;
            if (wr) begin
              if (col_end) begin
                in_col <= '0;
                in_row <= in_row + RW'(1);
              end else begin
                in_col <= in_col + CW'(1);
              end
            end
            if (emit) begin
              if (fe) begin
                in_col  <= '0;
                in_row  <= '0;
                out_col <= '0;
                out_row <= '0;
              end else if (out_col_end) begin
                out_col <= '0;
                out_row <= out_row + RW'(1);
              end else begin
                out_col <= out_col + CW'(1);
              end
            end
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  // datapath: products, then det and alpha term, then saturation at push
  always_ff @(posedge clk) begin
    if (state == F_IDLE && s_tvalid) begin
      sxx_r   <= s_tdata[23:0];
      syy_r   <= s_tdata[47:24];
      sxy_r   <= $signed(s_tdata[72:48]);
      flush_r <= s_tuser;
    end
    if (state == F_S1) begin
      p_xy  <= sxx_r * syy_r;
      p_s   <= sq[48:0];
      t2    <= tr * tr;
      q_mul <= in_row * cfg.w;
      d_mul <= cfg.r * cfg.w;
    end
    if (state == F_S2) begin
      det  <= $signed({3'b000, p_xy}) - $signed({2'b00, p_s});
      term <= tprod[65:16];
      ge   <= (q_sum >= d_sum);
    end
  end
endmodule

/* rtl/hrnt_back.sv */
// Back: line RAM writes and neighborhood scan through one RAM port
module hrnt_back import hrnt_pkg::*; #(
  parameter int MAX_RADIUS = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  logic          cmd_empty,
  input  cmd_t          cmd,
  output logic          cmd_pop,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [DW-1:0] m_tdata,
  output logic          m_tuser,
  output logic          m_tlast
);
  localparam int DEPTH = (2 * MAX_RADIUS + 1) * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int SHIFT = PW + AW;
  localparam int MB    = PW + 2;
  localparam logic [63:0] RECIP = (64'd1 << SHIFT) / DEPTH;

  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_WR    = 3'd1;
  localparam logic [2:0] B_CTR   = 3'd2;
  localparam logic [2:0] B_NB    = 3'd3;
  localparam logic [2:0] B_DRAIN = 3'd4;
  localparam logic [2:0] B_OUT   = 3'd5;

  localparam logic [1:0] K_WRITE  = 2'd0;
  localparam logic [1:0] K_CENTER = 2'd1;
  localparam logic [1:0] K_NEIGH  = 2'd2;

  typedef struct packed {
    logic [1:0]       kind;
    logic             last;
    logic [RESPW-1:0] data;
  } tag_t;

  logic [2:0]        state;
  cmd_t              cur;
  logic signed [4:0] dx, dy, rr;
  logic              nb_last;

  logic signed [CW+1:0] sx;
  logic signed [RW+1:0] sy;
  logic [CW-1:0]        nx;
  logic [RW-1:0]        ny;

  logic             i_v, a_v, b_v, c_v, d_v, e_v;
  tag_t             i_t, a_t, b_t, c_t, d_t, e_t;
  logic [CW-1:0]    i_x;
  logic [RW-1:0]    i_y;
  logic [PW-1:0]    a_p, b_p, c_p, c_qd;
  logic [PW+MB-1:0] b_pm;
  logic [PW-1:0]    rem;
  logic [AW-1:0]    d_addr;
  logic [RESPW-1:0] rdata;

  logic signed [RESPW-1:0] cval, resp_final;
  logic                    sup, done;

  assign rr      = $signed({2'b00, cfg.r});
  assign nb_last = (dx == rr) && (dy == rr);
  assign cmd_pop = (state == B_IDLE) && !cmd_empty;

  // edge clamp of the neighbor position
  always_comb begin
    sx = $signed({2'b00, cur.cx}) + (CW+2)'(dx);
    sy = $signed({2'b00, cur.cy}) + (RW+2)'(dy);
    if (sx < 0) nx = '0;
    else if (sx >= $signed({2'b00, cfg.w})) nx = cfg.w - CW'(1);
    else nx = sx[CW-1:0];
    if (sy < 0) ny = '0;
    else if (sy >= $signed({2'b00, cfg.h})) ny = cfg.h - RW'(1);
    else ny = sy[RW-1:0];
  end

  // slot sequencer: optional write, then, for an emitted item, center and the (2r+1)^2 window
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      i_v   <= 1'b0;
    end else begin
      i_v <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (!cmd_empty) begin
            cur   <= cmd;
            state <= cmd.wr ? B_WR : B_CTR;
          end
        end
        B_WR: begin
          i_v  <= 1'b1;
          i_t  <= '{kind: K_WRITE, last: 1'b0, data: cur.value};
          i_x  <= cur.wx;
          i_y  <= cur.wy;
          state <= cur.emit ? B_CTR : B_IDLE;
        end
        B_CTR: begin
          i_v  <= 1'b1;
          i_t  <= '{kind: K_CENTER, last: 1'b0, data: '0};
          i_x  <= cur.cx;
          i_y  <= cur.cy;
          dx   <= -rr;
          dy   <= -rr;
          state <= B_NB;
        end
        B_NB: begin
          i_v <= 1'b1;
          i_t <= '{kind: K_NEIGH, last: nb_last, data: '0};
          i_x <= nx;
          i_y <= ny;
          if (dx == rr) begin
            dx <= -rr;
            dy <= dy + 5'sd1;
          end else begin
            dx <= dx + 5'sd1;
          end
          if (nb_last) state <= B_DRAIN;
        end
        B_DRAIN: begin
          if (done) state <= B_OUT;
        end
        B_OUT: begin
          if (!m_tvalid || m_tready) state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // address pipeline: (y*w + x) mod DEPTH by reciprocal multiply
  always_comb begin
    rem = c_p - c_qd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
      d_v <= 1'b0;
      e_v <= 1'b0;
    end else begin
      a_v <= i_v;
      b_v <= a_v;
      c_v <= b_v;
      d_v <= c_v;
      e_v <= d_v && (d_t.kind != K_WRITE);
    end
  end

  always_ff @(posedge clk) begin
    a_t  <= i_t;
    a_p  <= i_y * cfg.w + PW'(i_x);
    b_t  <= a_t;
    b_p  <= a_p;
    b_pm <= a_p * RECIP[MB-1:0];
    c_t  <= b_t;
    c_p  <= b_p;
    c_qd <= PW'(b_pm[PW+MB-1:SHIFT] * DEPTH);
    d_t  <= c_t;
    d_addr <= (rem >= PW'(DEPTH)) ? AW'(rem - PW'(DEPTH)) : AW'(rem);
    e_t  <= d_t;
  end

  hrnt_ram #(
    .WIDTH (RESPW),
    .DEPTH (DEPTH)
  ) u_lines (
    .clk   (clk),
    .we    (d_v && (d_t.kind == K_WRITE)),
    .re    (d_v && (d_t.kind != K_WRITE)),
    .addr  (d_addr),
    .wdata (d_t.data),
    .rdata (rdata)
  );

  // window compare
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (done && (state != B_DRAIN)) ||
              (e_v && (e_t.kind == K_NEIGH) && e_t.last);
    end
  end

  always_ff @(posedge clk) begin
    if (e_v && (e_t.kind == K_CENTER)) begin
      cval <= $signed(rdata);
      sup  <= 1'b0;
    end else if (e_v && (e_t.kind == K_NEIGH) && ($signed(rdata) > cval)) begin
      sup <= 1'b1;
    end
  end

  assign resp_final = sup ? RESP_MIN : cval;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == B_OUT && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_OUT && (!m_tvalid || m_tready)) begin
      m_tdata <= {6'd0, resp_final, cur.oy, cur.ox[9:0]};
      m_tuser <= (resp_final > cfg.thr);
      m_tlast <= cur.fe;
    end
  end
endmodule

/* rtl/harris_response_nms_threshold_core.sv */
// Harris response, NMS and threshold core: top level with config registers.
// The front takes an item and runs it through states S1, S2 and S3 before it takes the next;
// S3 waits while the command queue is full. An emitted item then takes one RAM access per
// neighbor in the back through a 6-deep address pipe. The back works on one command at a
// time through the single line-RAM port; a queue of two commands parts the two.
// Reset (synchronous, rst high) clears counters, states, handshakes and config registers
// to their defaults; the line RAM is not cleared and has no clearing pass.
module harris_response_nms_threshold_core import hrnt_pkg::*; #(
  parameter int MAX_RADIUS = 4
) (
  input  logic             clk,
  input  logic             rst,
  // input items
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [DW-1:0]    s_tdata,   // sxx[23:0], syy[47:24], sxy[72:48], zero fill
  input  logic             s_tuser,   // req_type
  // result items
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [DW-1:0]    m_tdata,   // pixel_x[9:0], pixel_y[21:10], response[73:22]
  output logic             m_tuser,   // is_corner
  output logic             m_tlast,   // frame_end
  // configuration writes
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [RESPW-1:0] cfg_data
);
  logic [10:0]             frame_width;
  logic [11:0]             frame_height;
  logic [2:0]              nms_radius;
  logic signed [RESPW-1:0] corner_threshold;
  logic [15:0]             alpha_q16;

  cfg_t cfg;
  cmd_t cmd_in, cmd_out;
  logic cmd_push, cmd_full, cmd_pop, cmd_empty;

  // register writes, no read-back
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width      <= 11'd640;
      frame_height     <= 12'd480;
      nms_radius       <= 3'd2;
      corner_threshold <= '0;
      alpha_q16        <= 16'd3932;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  frame_width      <= cfg_data[10:0];
        REG_HEIGHT: frame_height     <= cfg_data[11:0];
        REG_RADIUS: nms_radius       <= cfg_data[2:0];
        REG_THRESH: corner_threshold <= $signed(cfg_data);
        REG_ALPHA:  alpha_q16        <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // effective values: zero sizes count as one, oversize values clip
  always_comb begin
    if (frame_width == 11'd0) cfg.w = CW'(1);
    else if ({2'b00, frame_width} > 13'(MAX_WIDTH)) cfg.w = CW'(MAX_WIDTH);
    else cfg.w = frame_width;
    cfg.h = (frame_height == 12'd0) ? RW'(1) : frame_height;
    cfg.r = ({1'b0, nms_radius} > 4'(MAX_RADIUS)) ? RADW'(MAX_RADIUS) : nms_radius;
    cfg.thr   = corner_threshold;
    cfg.alpha = alpha_q16;
  end

  hrnt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cmd_push (cmd_push),
    .cmd      (cmd_in),
    .cmd_full (cmd_full)
  );

  hrnt_cmd_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .empty (cmd_empty)
  );

  hrnt_back #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );
endmodule

/* rtl/hrnt_checker.sv */
// Port checker for the Harris NMS core, bound to the top level
`include "harris_response_nms_threshold_core_defines.svh"

module hrnt_checker import hrnt_pkg::*; (
  input logic          clk,
  input logic          rst,
  input logic          s_tvalid,
  input logic          s_tready,
  input logic          m_tvalid,
  input logic          m_tready,
  input logic [DW-1:0] m_tdata,
  input logic          m_tuser,
  input logic          m_tlast
);
  `HRNT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
  `HRNT_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast))
  `HRNT_ASSERT(a_sup_not_corner, m_tvalid && (m_tdata[73:22] == RESP_MIN), !m_tuser)
  `HRNT_ASSERT(a_quiet_after_reset, $past(rst), !m_tvalid && (s_tready || !s_tvalid))
endmodule

bind harris_response_nms_threshold_core hrnt_checker u_hrnt_checker (.*);
